// ===== sv/assembly_lexer_top_defines.svh =====
// Assertion macros shared by the lexer checker.
// No dependencies; included by sv/alex_checker.sv.
`ifndef ASSEMBLY_LEXER_TOP_DEFINES_SVH
`define ASSEMBLY_LEXER_TOP_DEFINES_SVH

// Clocked assertion, held off while reset is low.
`define ALEX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define ALEX_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/alex_pkg.sv =====
// Types, character codes and record builders for the assembly lexer.
// No dependencies; imported by every lexer module.
package alex_pkg;

    localparam int LINE_W        = 16;
    localparam int LEN_W         = 8;
    localparam int MAX_TOKEN_LEN = 255;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = 2;

    localparam logic [1:0] REC_BYTE  = 2'd0;
    localparam logic [1:0] REC_END   = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    localparam logic [2:0] TK_IDENT  = 3'd0;
    localparam logic [2:0] TK_INT    = 3'd1;
    localparam logic [2:0] TK_FLOAT  = 3'd2;
    localparam logic [2:0] TK_STRING = 3'd3;
    localparam logic [2:0] TK_CHAR   = 3'd4;
    localparam logic [2:0] TK_OPER   = 3'd5;

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_V      = 8'h76;

    typedef enum logic [3:0] {
        LC_WS      = 4'd0,
        LC_IDENT   = 4'd1,
        LC_INT     = 4'd2,
        LC_FLOAT   = 4'd3,
        LC_STRING  = 4'd4,
        LC_CHAR    = 4'd5,
        LC_PFLOAT  = 4'd6,
        LC_ESCAPE  = 4'd7,
        LC_COMMENT = 4'd8,
        LC_ERROR   = 4'd9
    } t_lex_class;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        record_kind;
        logic [7:0]        text_byte;
        logic [2:0]        token_kind;
        logic [LINE_W-1:0] line_number;
        logic [LEN_W-1:0]  token_length;
        logic              last_record;
    } t_out_word;

    typedef struct packed {
        logic [1:0]          count;
        t_out_word [2:0]     recs;
    } t_bundle;

    typedef struct packed {
        logic    push;
        t_bundle bundle;
    } t_q_wr;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_q_rd;

    typedef struct packed {
        logic       has;
        logic [2:0] kind;
    } t_end_info;

    typedef struct packed {
        logic       ok;
        logic [7:0] dec;
    } t_esc;

    function automatic t_end_info f_end_info(input t_lex_class cls,
                                             input logic [LEN_W-1:0] len);
        t_end_info r;
        r.has  = 1'b1;
        r.kind = TK_IDENT;
        case (cls)
            LC_IDENT:  r.kind = TK_IDENT;
            LC_INT:    r.kind = TK_INT;
            LC_FLOAT:  r.kind = TK_FLOAT;
            LC_STRING: r.kind = TK_STRING;
            LC_ESCAPE: r.kind = TK_STRING;
            LC_CHAR:   r.kind = TK_CHAR;
            LC_PFLOAT: r.kind = (len == LEN_W'(1)) ? TK_OPER : TK_FLOAT;
            default:   r.has  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_esc f_escape(input logic [7:0] c);
        t_esc r;
        r.ok  = 1'b1;
        r.dec = c;
        case (c)
            CH_N:      r.dec = CH_LF;
            CH_R:      r.dec = CH_CR;
            CH_T:      r.dec = CH_TAB;
            CH_F:      r.dec = CH_FF;
            CH_V:      r.dec = CH_VT;
            CH_BSLASH: r.dec = CH_BSLASH;
            default:   r.ok  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_out_word f_byte_rec(input logic [7:0] b);
        t_out_word r;
        r             = '0;
        r.record_kind = REC_BYTE;
        r.text_byte   = b;
        return r;
    endfunction

    function automatic t_out_word f_end_rec(input logic [2:0] kind,
                                            input logic [LINE_W-1:0] line,
                                            input logic [LEN_W-1:0] len);
        t_out_word r;
        r              = '0;
        r.record_kind  = REC_END;
        r.token_kind   = kind;
        r.line_number  = line;
        r.token_length = len;
        return r;
    endfunction

    function automatic t_out_word f_err_rec(input logic [7:0] b,
                                            input logic [LINE_W-1:0] line);
        t_out_word r;
        r             = '0;
        r.record_kind = REC_ERROR;
        r.text_byte   = b;
        r.line_number = line;
        return r;
    endfunction

endpackage

// ===== sv/assembly_lexer_top.sv =====
// Assembly lexer top level: front end, bundle queue and back end.
// Depends on alex_pkg, alex_front, alex_queue and alex_back.
//
// Input channel: one source byte per word, with last_byte marking the end
// of a source text. Output channel: one record per word (token byte, token
// end or escape error); last_record flags the final record a byte caused.
// Each input byte yields zero to three records.
// The first record of a byte passes through the queue write, the bundle
// register and the output register.
// Throughput: one byte per cycle while bytes give at most one record each
// and the receiver keeps up; the output side moves one record per cycle.
// A four-bundle queue absorbs bursts.
// Reset: lexer returns to whitespace with line one and length zero; the
// queue and output register empty.
// Receiver stall: the output word holds, the back end stops unpacking, the
// queue fills and o_in_ready drops once four bundles are waiting.
module assembly_lexer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  alex_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output alex_pkg::t_out_word o_out_data
);
    import alex_pkg::*;

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    alex_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_wr       (q_wr)
    );

    alex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    alex_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (q_rd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/alex_front.sv =====
// Front end: accepts source bytes, runs the lexer state and builds
// one bundle of up to three records per byte. Depends on alex_pkg.
module alex_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  alex_pkg::t_in_word i_in_data,
    input  logic               i_full,
    output alex_pkg::t_q_wr    o_wr
);
    import alex_pkg::*;

    t_lex_class        r_class, n_class;
    logic [LINE_W-1:0] r_line, n_line;
    logic [LEN_W-1:0]  r_len, n_len;

    logic              accept;
    logic [7:0]        c;
    logic              is_digit;
    logic              e1, ap, op, er, fin;
    logic [7:0]        apv;
    logic [LEN_W-1:0]  len_base, len_app;
    logic [LINE_W-1:0] line_inc;
    t_end_info         ei1, eif;
    t_esc              esc;
    t_out_word [3:0]   cand;
    logic [3:0]        cand_v;
    t_bundle           bun;
    logic [1:0]        n;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        c        = i_in_data.source_byte;
        is_digit = (c >= CH_0) && (c <= CH_9);
        esc      = f_escape(c);
        line_inc = (r_line != '1) ? r_line + LINE_W'(1) : r_line;
        n_class  = r_class;
        n_len    = r_len;
        n_line   = r_line;
        e1       = 1'b0;
        ap       = 1'b0;
        op       = 1'b0;
        er       = 1'b0;
        apv      = c;
        case (r_class)
            LC_ERROR: begin
            end
            LC_ESCAPE: begin
                if (esc.ok) begin
                    ap      = 1'b1;
                    apv     = esc.dec;
                    n_class = LC_STRING;
                end else begin
                    er      = 1'b1;
                    n_class = LC_ERROR;
                end
            end
            LC_COMMENT: begin
                if (c == CH_LF || c == CH_CR) begin
                    n_class = LC_WS;
                    n_line  = line_inc;
                end
            end
            default: begin
                if (is_digit) begin
                    ap = 1'b1;
                    if (r_class == LC_WS) begin
                        n_class = LC_INT;
                    end else if (r_class == LC_PFLOAT) begin
                        n_class = LC_FLOAT;
                    end
                end else begin
                    case (c)
                        CH_DOT: begin
                            if (r_class == LC_WS) begin
                                n_class = LC_PFLOAT;
                                ap      = 1'b1;
                            end else if (r_class == LC_INT) begin
                                n_class = LC_FLOAT;
                                ap      = 1'b1;
                            end else if (r_class == LC_STRING) begin
                                ap = 1'b1;
                            end else begin
                                op = 1'b1;
                            end
                        end
                        CH_COMMA, CH_COLON, CH_MINUS: begin
                            if (r_class == LC_STRING) begin
                                ap = 1'b1;
                            end else begin
                                op = 1'b1;
                            end
                        end
                        CH_SPACE, CH_TAB, CH_FF, CH_VT: begin
                            e1      = 1'b1;
                            n_class = LC_WS;
                        end
                        CH_LF, CH_CR: begin
                            e1      = 1'b1;
                            n_class = LC_WS;
                            n_line  = line_inc;
                        end
                        CH_DQUOTE: begin
                            e1 = 1'b1;
                            if (r_class != LC_STRING) begin
                                n_class = LC_STRING;
                                ap      = 1'b1;
                            end else begin
                                n_class = LC_WS;
                            end
                        end
                        CH_BSLASH: begin
                            if (r_class == LC_STRING) begin
                                n_class = LC_ESCAPE;
                            end else begin
                                op = 1'b1;
                            end
                        end
                        CH_SQUOTE: begin
                            e1 = 1'b1;
                            if (r_class != LC_CHAR) begin
                                n_class = LC_CHAR;
                                ap      = 1'b1;
                            end else begin
                                n_class = LC_WS;
                            end
                        end
                        CH_SEMI: begin
                            if (r_class == LC_STRING) begin
                                ap = 1'b1;
                            end else begin
                                e1      = 1'b1;
                                n_class = LC_COMMENT;
                            end
                        end
                        default: begin
                            if (r_class == LC_WS || r_class == LC_INT ||
                                r_class == LC_FLOAT) begin
                                e1      = 1'b1;
                                n_class = LC_IDENT;
                            end
                            ap = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        if (op) begin
            e1      = 1'b1;
            ap      = 1'b1;
            n_class = LC_WS;
        end

        len_base = e1 ? '0 : r_len;
        len_app  = (len_base < LEN_W'(MAX_TOKEN_LEN)) ? len_base + LEN_W'(1) : len_base;

        if (op || er) begin
            n_len = '0;
        end else if (ap) begin
            n_len = len_app;
        end else if (e1) begin
            n_len = '0;
        end

        ei1 = f_end_info(r_class, r_len);
        fin = i_in_data.last_byte && (n_class != LC_ERROR);
        eif = f_end_info(n_class, n_len);

        cand[0]   = f_end_rec(ei1.kind, r_line, r_len);
        cand_v[0] = e1 && ei1.has;
        cand[1]   = er ? f_err_rec(c, r_line) : f_byte_rec(apv);
        cand_v[1] = ap || er;
        cand[2]   = f_end_rec(TK_OPER, r_line, len_app);
        cand_v[2] = op;
        cand[3]   = f_end_rec(eif.kind, r_line, n_len);
        cand_v[3] = fin && eif.has;

        bun = '0;
        n   = '0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && n != 2'd3) begin
                bun.recs[n] = cand[i];
                n           = n + 2'd1;
            end
        end
        if (n != 2'd0) begin
            bun.recs[n - 2'd1].last_record = 1'b1;
        end
        bun.count = n;

        o_wr.push   = accept && (n != 2'd0);
        o_wr.bundle = bun;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= LC_WS;
            r_line  <= LINE_W'(1);
            r_len   <= '0;
        end else if (accept) begin
            if (i_in_data.last_byte) begin
                r_class <= LC_WS;
                r_line  <= LINE_W'(1);
                r_len   <= '0;
            end else begin
                r_class <= n_class;
                r_line  <= n_line;
                r_len   <= n_len;
            end
        end
    end

endmodule

// ===== sv/alex_queue.sv =====
// Bundle queue between the lexer front end and the record back end.
// Depends on alex_pkg.
module alex_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  alex_pkg::t_q_wr i_wr,
    output logic            o_full,
    input  logic            i_pop,
    output alex_pkg::t_q_rd o_rd
);
    import alex_pkg::*;

    t_bundle              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]     r_count, n_count;
    logic                 do_pop;

    assign o_full       = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_rd.valid   = (r_count != '0);
    assign o_rd.bundle  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_rd.valid;

    always_comb begin
        n_count = r_count;
        if (i_wr.push && !do_pop) begin
            n_count = r_count + (Q_PTR_W+1)'(1);
        end else if (!i_wr.push && do_pop) begin
            n_count = r_count - (Q_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/alex_back.sv =====
// Back end: unpacks bundles into single records and drives the output
// register. Depends on alex_pkg.
module alex_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  alex_pkg::t_q_rd     i_rd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output alex_pkg::t_out_word o_out_data
);
    import alex_pkg::*;

    logic       r_bun_valid;
    t_bundle    r_bun;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_word  r_out;

    logic       out_load;
    logic       bun_done;
    logic       bun_load;

    assign out_load    = r_bun_valid && (!r_out_valid || i_out_ready);
    assign bun_done    = out_load && (r_idx == r_bun.count - 2'd1);
    assign bun_load    = !r_bun_valid || bun_done;
    assign o_pop       = bun_load && i_rd.valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_bun.recs[r_idx];
        end
        if (bun_load) begin
            r_bun <= i_rd.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bun_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (bun_load) begin
                r_bun_valid <= i_rd.valid;
                r_idx       <= '0;
            end else if (out_load) begin
                r_idx <= r_idx + 2'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/alex_checker.sv =====
// Port-level checks for the assembly lexer, bound to the top level.
// Depends on alex_pkg and assembly_lexer_top_defines.svh.
`include "assembly_lexer_top_defines.svh"

module alex_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input alex_pkg::t_in_word  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input alex_pkg::t_out_word o_out_data
);
    import alex_pkg::*;

    `ALEX_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "output word changed while stalled")
    `ALEX_ASSERT_RST(a_reset_empty, !i_rst_n |=> o_in_ready && !o_out_valid, "not empty after reset")
    `ALEX_ASSERT(a_end_fields, o_out_valid && o_out_data.record_kind == REC_END |-> o_out_data.line_number != '0 && o_out_data.text_byte == '0, "bad token end record")
    `ALEX_ASSERT(a_byte_fields, o_out_valid && o_out_data.record_kind == REC_BYTE |-> o_out_data.line_number == '0 && o_out_data.token_length == '0 && o_out_data.token_kind == TK_IDENT, "bad token byte record")

endmodule

bind assembly_lexer_top alex_checker u_alex_checker (.*);
